// ----- rtl/core/iea_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iea_pkg
// shared types and constants of the idle entry aging table
// ----------------------------------------------------------------------------
package iea_pkg;

  // default depths
  localparam int unsigned TABLE_DEPTH_DEF = 32;
  localparam int unsigned HEAP_DEPTH_DEF  = 64;

  // field widths
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned TSTAMP_W = 64;
  localparam int unsigned WINDOW_W = 40;
  localparam int unsigned COUNT_W  = 6;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 40'd600000000;

  // result status codes
  localparam logic [1:0] ST_UPDATED = 2'd0;
  localparam logic [1:0] ST_CREATED = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // input word
  typedef struct packed {
    logic                func;
    logic [KEY_W-1:0]    process_id;
    logic [TSTAMP_W-1:0] now_time;
  } iea_in_t;

  // result word
  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] evicted_count;
    logic               record_dropped;
  } iea_out_t;

  // one stored record: table entry or heap entry
  typedef struct packed {
    logic [TSTAMP_W-1:0] tstamp;
    logic [KEY_W-1:0]    key;
  } iea_rec_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;   // latch input word, clear scan and result state
    logic scan_clr;  // restart the table scan
    logic scan_rd;   // read table entry at scan index
    logic cmp_lk;    // lookup compare, advance scan
    logic cmp_ev;    // eviction compare, advance scan
    logic lk_dec;    // settle lookup outcome, write table entry
    logic push_init; // open hole at heap tail
    logic rd_par;    // read parent of hole
    logic mv_par;    // move parent down into hole
    logic wr_rec;    // write moving record into hole
    logic rd_top;    // read heap root
    logic pop;       // take root as victim, read last record
    logic ld_last;   // last record becomes the moving record, hole at root
    logic rd_kids;   // read both children of hole
    logic sd_step;   // one sift-down step
    logic out_load;  // load result register
  } iea_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic lk_go;
    logic heap_full;
    logic heap_empty;
    logic cnt_one;
    logic at_root;
    logic par_stop;
    logic expired;
    logic sd_done;
  } iea_sts_t;

endpackage

// ----- rtl/core/iea_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iea_ctrl
// sequencer for lookup, heap push, eviction pops and result hand-off
// ----------------------------------------------------------------------------
module iea_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  iea_pkg::iea_sts_t sts_i,
  output iea_pkg::iea_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SC_RD  = 4'd1;
  localparam logic [3:0] S_SC_CMP = 4'd2;
  localparam logic [3:0] S_LK_DEC = 4'd3;
  localparam logic [3:0] S_P_INIT = 4'd4;
  localparam logic [3:0] S_P_CHK  = 4'd5;
  localparam logic [3:0] S_P_CMP  = 4'd6;
  localparam logic [3:0] S_P_WR   = 4'd7;
  localparam logic [3:0] S_EV_RD  = 4'd8;
  localparam logic [3:0] S_EV_CHK = 4'd9;
  localparam logic [3:0] S_D_LAST = 4'd10;
  localparam logic [3:0] S_D_RD   = 4'd11;
  localparam logic [3:0] S_D_CMP  = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0] state_q, state_d;
  logic       evmode_q, evmode_d;
  logic       out_valid_q, out_valid_d;

  // next state and commands
  always_comb begin
    state_d  = state_q;
    evmode_d = evmode_q;
    cmd_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          evmode_d      = 1'b0;
          state_d       = S_SC_RD;
        end
      end
      S_SC_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = S_SC_CMP;
      end
      S_SC_CMP: begin
        cmd_o.cmp_lk = !evmode_q;
        cmd_o.cmp_ev = evmode_q;
        if (sts_i.scan_last) begin
          state_d = evmode_q ? S_EV_RD : S_LK_DEC;
        end else begin
          state_d = S_SC_RD;
        end
      end
      S_LK_DEC: begin
        cmd_o.lk_dec = 1'b1;
        if (!sts_i.lk_go) begin
          state_d = S_DONE;
        end else if (sts_i.heap_full) begin
          state_d = S_EV_RD;
        end else begin
          state_d = S_P_INIT;
        end
      end
      S_P_INIT: begin
        cmd_o.push_init = 1'b1;
        state_d         = S_P_CHK;
      end
      S_P_CHK: begin
        if (sts_i.at_root) begin
          state_d = S_P_WR;
        end else begin
          cmd_o.rd_par = 1'b1;
          state_d      = S_P_CMP;
        end
      end
      S_P_CMP: begin
        if (sts_i.par_stop) begin
          state_d = S_P_WR;
        end else begin
          cmd_o.mv_par = 1'b1;
          state_d      = S_P_CHK;
        end
      end
      S_P_WR: begin
        cmd_o.wr_rec = 1'b1;
        state_d      = S_EV_RD;
      end
      S_EV_RD: begin
        if (sts_i.heap_empty) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_top = 1'b1;
          state_d      = S_EV_CHK;
        end
      end
      S_EV_CHK: begin
        if (!sts_i.expired) begin
          state_d = S_DONE;
        end else begin
          cmd_o.pop = 1'b1;
          if (sts_i.cnt_one) begin
            cmd_o.scan_clr = 1'b1;
            evmode_d       = 1'b1;
            state_d        = S_SC_RD;
          end else begin
            state_d = S_D_LAST;
          end
        end
      end
      S_D_LAST: begin
        cmd_o.ld_last = 1'b1;
        state_d       = S_D_RD;
      end
      S_D_RD: begin
        cmd_o.rd_kids = 1'b1;
        state_d       = S_D_CMP;
      end
      S_D_CMP: begin
        cmd_o.sd_step = 1'b1;
        if (sts_i.sd_done) begin
          cmd_o.scan_clr = 1'b1;
          evmode_d       = 1'b1;
          state_d        = S_SC_RD;
        end else begin
          state_d = S_D_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      evmode_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      evmode_q    <= evmode_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/iea_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iea_dp
// key table, activity heap memory and the compare logic around them
// ----------------------------------------------------------------------------
module iea_dp #(
  parameter int unsigned TABLE_DEPTH = iea_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned HEAP_DEPTH  = iea_pkg::HEAP_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  iea_pkg::iea_in_t                in_data_i,
  input  logic                            cfg_we_i,
  input  logic [iea_pkg::WINDOW_W-1:0]    cfg_data_i,
  input  iea_pkg::iea_cmd_t               cmd_i,
  output iea_pkg::iea_sts_t               sts_o,
  output iea_pkg::iea_out_t               out_data_o
);

  localparam int unsigned TW = $clog2(TABLE_DEPTH);
  localparam int unsigned HW = $clog2(HEAP_DEPTH);
  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned XW = HW + 2;
  localparam int unsigned TSW = iea_pkg::TSTAMP_W;

  // configuration and latched input word
  logic [iea_pkg::WINDOW_W-1:0] window_q;
  logic                         func_q;
  logic [iea_pkg::KEY_W-1:0]    key_q;
  logic [TSW-1:0]               now_q;

  // key table
  iea_pkg::iea_rec_t        tmem [TABLE_DEPTH];
  iea_pkg::iea_rec_t        trd_q;
  logic [TABLE_DEPTH-1:0]   valid_q;
  logic [TW-1:0]            sidx_q;
  logic                     found_q, free_q;
  logic [TW-1:0]            found_idx_q, free_idx_q;

  // heap
  iea_pkg::iea_rec_t        hmem [HEAP_DEPTH];
  iea_pkg::iea_rec_t        rda_q, rdb_q, rec_q, top_q;
  logic [CW-1:0]            cnt_q;
  logic [HW-1:0]            hidx_q;

  // per-item result
  logic [1:0]                  status_q;
  logic [iea_pkg::COUNT_W-1:0] freed_q;
  logic                        dropped_q;
  iea_pkg::iea_out_t           out_q;

  // combinational helpers
  logic [TW-1:0]     lk_slot;
  logic              lk_go;
  logic              heap_full;
  logic [HW-1:0]     parent;
  logic [XW-1:0]     kid_l, kid_r, cnt_x;
  logic              l_ok, r_ok, sd_done;
  logic [XW-1:0]     kid_sel;
  iea_pkg::iea_rec_t kid_rec;
  logic [TSW:0]      lim_sum;
  logic              expired;
  logic              scan_hit_ev;
  logic [HW-1:0]     a_addr;
  logic              a_en;
  logic              h_we;
  logic [HW-1:0]     h_waddr;
  iea_pkg::iea_rec_t h_wdata;

  // lookup outcome
  assign lk_slot   = found_q ? found_idx_q : free_idx_q;
  assign lk_go     = found_q || (!func_q && free_q);
  assign heap_full = (cnt_q == CW'(HEAP_DEPTH));

  // heap index arithmetic
  assign parent = (hidx_q - 1'b1) >> 1;
  assign kid_l  = XW'({hidx_q, 1'b1});
  assign kid_r  = kid_l + 1'b1;
  assign cnt_x  = XW'(cnt_q);

  // sift-down choice between hole record and children
  assign l_ok    = (kid_l < cnt_x) && (rda_q.tstamp < rec_q.tstamp);
  assign r_ok    = (kid_r < cnt_x) &&
                   (rdb_q.tstamp < (l_ok ? rda_q.tstamp : rec_q.tstamp));
  assign sd_done = !l_ok && !r_ok;
  assign kid_sel = r_ok ? kid_r : kid_l;
  assign kid_rec = r_ok ? rdb_q : rda_q;

  // saturating window sum against current time
  assign lim_sum = {1'b0, rda_q.tstamp} + (TSW + 1)'(window_q);
  assign expired = !lim_sum[TSW] && (lim_sum[TSW-1:0] < now_q);

  // eviction match: same key and same stamp
  assign scan_hit_ev = valid_q[sidx_q] && (trd_q.key == top_q.key) &&
                       (trd_q.tstamp == top_q.tstamp);

  // heap read port a address
  always_comb begin
    a_addr = '0;
    a_en   = 1'b1;
    priority if (cmd_i.rd_par) begin
      a_addr = parent;
    end else if (cmd_i.pop) begin
      a_addr = HW'(cnt_q - 1'b1);
    end else if (cmd_i.rd_kids) begin
      a_addr = kid_l[HW-1:0];
    end else if (cmd_i.rd_top) begin
      a_addr = '0;
    end else begin
      a_en = 1'b0;
    end
  end

  // heap write port
  always_comb begin
    h_we    = 1'b0;
    h_waddr = hidx_q;
    h_wdata = rec_q;
    priority if (cmd_i.mv_par) begin
      h_we    = 1'b1;
      h_wdata = rda_q;
    end else if (cmd_i.wr_rec) begin
      h_we = 1'b1;
    end else if (cmd_i.sd_step) begin
      h_we    = 1'b1;
      h_wdata = sd_done ? rec_q : kid_rec;
    end
  end

  // heap memory
  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hmem[h_waddr] <= h_wdata;
    end
    if (a_en) begin
      rda_q <= hmem[a_addr];
    end
    if (cmd_i.rd_kids) begin
      rdb_q <= hmem[kid_r[HW-1:0]];
    end
  end

  // table memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.lk_dec && lk_go) begin
      tmem[lk_slot] <= '{tstamp: now_q, key: key_q};
    end
    if (cmd_i.scan_rd) begin
      trd_q <= tmem[sidx_q];
    end
  end

  // input word and heap records
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q <= in_data_i.func;
      key_q  <= in_data_i.process_id;
      now_q  <= in_data_i.now_time;
    end
    if (cmd_i.push_init) begin
      rec_q <= '{tstamp: now_q, key: key_q};
    end else if (cmd_i.ld_last) begin
      rec_q <= rda_q;
    end
    if (cmd_i.pop) begin
      top_q <= rda_q;
    end
    if (cmd_i.out_load) begin
      out_q <= '{status: status_q, evicted_count: freed_q, record_dropped: dropped_q};
    end
  end

  // scan bookkeeping, hole index, result state
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in || cmd_i.scan_clr) begin
      sidx_q <= '0;
    end else if (cmd_i.cmp_lk || cmd_i.cmp_ev) begin
      if (sidx_q != TW'(TABLE_DEPTH - 1)) begin
        sidx_q <= sidx_q + 1'b1;
      end
    end
    if (cmd_i.cmp_lk) begin
      if (valid_q[sidx_q] && (trd_q.key == key_q)) begin
        found_idx_q <= sidx_q;
      end
      if (!valid_q[sidx_q] && !free_q) begin
        free_idx_q <= sidx_q;
      end
    end
    if (cmd_i.push_init) begin
      hidx_q <= HW'(cnt_q);
    end else if (cmd_i.mv_par) begin
      hidx_q <= parent;
    end else if (cmd_i.ld_last) begin
      hidx_q <= '0;
    end else if (cmd_i.sd_step && !sd_done) begin
      hidx_q <= kid_sel[HW-1:0];
    end
  end

  // control state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= iea_pkg::WINDOW_RESET;
      valid_q   <= '0;
      cnt_q     <= '0;
      found_q   <= 1'b0;
      free_q    <= 1'b0;
      status_q  <= iea_pkg::ST_UPDATED;
      freed_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_data_i;
      end
      if (cmd_i.load_in) begin
        found_q   <= 1'b0;
        free_q    <= 1'b0;
        freed_q   <= '0;
        dropped_q <= 1'b0;
      end
      if (cmd_i.cmp_lk) begin
        if (valid_q[sidx_q] && (trd_q.key == key_q)) begin
          found_q <= 1'b1;
        end
        if (!valid_q[sidx_q]) begin
          free_q <= 1'b1;
        end
      end
      if (cmd_i.cmp_ev && scan_hit_ev) begin
        valid_q[sidx_q] <= 1'b0;
        if (freed_q != '1) begin
          freed_q <= freed_q + 1'b1;
        end
      end
      if (cmd_i.lk_dec) begin
        if (found_q) begin
          status_q <= iea_pkg::ST_UPDATED;
        end else if (func_q) begin
          status_q <= iea_pkg::ST_ABSENT;
        end else if (free_q) begin
          status_q <= iea_pkg::ST_CREATED;
        end else begin
          status_q <= iea_pkg::ST_FULL;
        end
        if (lk_go) begin
          valid_q[lk_slot] <= 1'b1;
          dropped_q        <= heap_full;
        end
      end
      if (cmd_i.push_init) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (cmd_i.pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign sts_o.scan_last  = (sidx_q == TW'(TABLE_DEPTH - 1));
  assign sts_o.lk_go      = lk_go;
  assign sts_o.heap_full  = heap_full;
  assign sts_o.heap_empty = (cnt_q == '0);
  assign sts_o.cnt_one    = (cnt_q == CW'(1));
  assign sts_o.at_root    = (hidx_q == '0);
  assign sts_o.par_stop   = (rda_q.tstamp <= rec_q.tstamp);
  assign sts_o.expired    = expired;
  assign sts_o.sd_done    = sd_done;

  assign out_data_o = out_q;

endmodule

// ----- rtl/core/idle_entry_aging_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_entry_aging_table
// table of keys with last-activity stamps, aged out through a min-heap
// ----------------------------------------------------------------------------
// Input channel in_valid_i / in_stall_o carries one word: func, process_id,
// now_time. Output channel out_valid_o / out_stall_i returns one result word
// per input word: status, evicted_count, record_dropped.
// The user must write the window register over cfg_valid_i / cfg_ready_o
// only while idle; the block itself does not enforce this. One word is
// worked on at a time: a key lookup that scans the table one entry at a
// time, a heap push (skipped if the heap is full), a root check, and for
// each record popped a sift-down (unless the heap held only that record)
// plus another table scan before the next root check, then hand-off. A
// refused word (absent key or full table) goes from the lookup straight
// to hand-off.
// The finished result sits in an output register; the next word is taken
// while it waits. If the receiver stalls, the block holds at hand-off until
// that register frees up. Reset empties the table and the heap at once and
// restores the default window; no clearing pass is needed.
// ----------------------------------------------------------------------------
module idle_entry_aging_table #(
  parameter int unsigned TABLE_DEPTH = iea_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned HEAP_DEPTH  = iea_pkg::HEAP_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  iea_pkg::iea_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output iea_pkg::iea_out_t            out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [iea_pkg::WINDOW_W-1:0] cfg_data_i
);

  iea_pkg::iea_cmd_t cmd;
  iea_pkg::iea_sts_t sts;

  assign cfg_ready_o = 1'b1;

  // sequencer
  iea_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // storage and compare datapath
  iea_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .HEAP_DEPTH  (HEAP_DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// ----- rtl/core/iea_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iea_chk
// port-level checks of the idle entry aging table, bound to the top level
// ----------------------------------------------------------------------------
module iea_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input iea_pkg::iea_out_t out_data_o
);

  // a taken word keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while block reports ready next cycle");

  // refused words change nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == iea_pkg::ST_ABSENT ||
                    out_data_o.status == iea_pkg::ST_FULL)
      |-> out_data_o.evicted_count == '0 && !out_data_o.record_dropped)
    else $error("refused word reports evictions or a dropped record");

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

  // no result without a word having been taken since reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while block was idle");

endmodule

bind idle_entry_aging_table iea_chk u_iea_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- test/idle_entry_aging_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_entry_aging_table_tb
// Drives lookup/insert/touch words through the aging table under random
// valid and stall gaps. Every accepted word is run through an in-bench model
// of the key table and activity min-heap. Each result word is compared field
// by field with the oldest predicted one. The idle window is rewritten
// between phases, including its extremes.
// ----------------------------------------------------------------------------
module idle_entry_aging_table_tb;
  import iea_pkg::*;

  localparam int unsigned TBL_N = TABLE_DEPTH_DEF;
  localparam int unsigned HEAP_N = HEAP_DEPTH_DEF;
  localparam logic FN_INSERT = 1'b0;
  localparam logic FN_TOUCH  = 1'b1;
  localparam logic [WINDOW_W-1:0] WINDOW_MAX = '1;
  localparam int unsigned HOLD_CYCLES = 4000;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned PHASE_WORDS = 316;
  localparam int unsigned POOL_N = 40;

  // model of the key table and the activity heap
  class aging_scoreboard;
    logic [WINDOW_W-1:0] window;
    bit                  used [TBL_N];
    logic [KEY_W-1:0]    tkey [TBL_N];
    logic [TSTAMP_W-1:0] tlast [TBL_N];
    logic [TSTAMP_W-1:0] htime [HEAP_N];
    logic [KEY_W-1:0]    hkey [HEAP_N];
    int                  hcount;
    iea_out_t            expected_q [$];
    int                  errors;

    function new();
      window = WINDOW_RESET;
      hcount = 0;
      errors = 0;
      foreach (used[i]) used[i] = 0;
    endfunction

    function int find_key(logic [KEY_W-1:0] k);
      foreach (used[i]) if (used[i] && tkey[i] == k) return i;
      return -1;
    endfunction

    function void swap_recs(int a, int b);
      logic [TSTAMP_W-1:0] t;
      logic [KEY_W-1:0] k;
      t = htime[a]; k = hkey[a];
      htime[a] = htime[b]; hkey[a] = hkey[b];
      htime[b] = t; hkey[b] = k;
    endfunction

    // work out the result of one accepted word
    function void note_input(iea_in_t w);
      iea_out_t r;
      int s, i, p, l, m, freed;
      logic [TSTAMP_W:0] sum;
      logic [TSTAMP_W-1:0] lim, t;
      logic [KEY_W-1:0] k;
      r = '0;
      freed = 0;
      s = find_key(w.process_id);
      if (s < 0) begin
        if (w.func == FN_TOUCH) begin
          r.status = ST_ABSENT;
        end else begin
          for (i = 0; i < TBL_N; i++) if (!used[i]) begin s = i; break; end
          if (s < 0) begin
            r.status = ST_FULL;
          end else begin
            used[s] = 1;
            tkey[s] = w.process_id;
            r.status = ST_CREATED;
          end
        end
      end else begin
        r.status = ST_UPDATED;
      end
      if (s >= 0) begin
        tlast[s] = w.now_time;
        // push record and sift up
        if (hcount < HEAP_N) begin
          htime[hcount] = w.now_time;
          hkey[hcount] = w.process_id;
          i = hcount;
          hcount++;
          while (i > 0) begin
            p = (i - 1) / 2;
            if (htime[p] <= htime[i]) break;
            swap_recs(p, i);
            i = p;
          end
        end else begin
          r.record_dropped = 1'b1;
        end
        // pop stale records, free keys whose stamp still matches
        while (hcount != 0) begin
          t = htime[0];
          k = hkey[0];
          sum = {1'b0, t} + {{(TSTAMP_W+1-WINDOW_W){1'b0}}, window};
          lim = sum[TSTAMP_W] ? '1 : sum[TSTAMP_W-1:0];
          if (lim >= w.now_time) break;
          hcount--;
          if (hcount != 0) begin
            htime[0] = htime[hcount];
            hkey[0] = hkey[hcount];
            i = 0;
            forever begin
              l = 2 * i + 1;
              m = i;
              if (l < hcount && htime[l] < htime[m]) m = l;
              if (l + 1 < hcount && htime[l+1] < htime[m]) m = l + 1;
              if (m == i) break;
              swap_recs(i, m);
              i = m;
            end
          end
          s = find_key(k);
          if (s >= 0 && tlast[s] == t) begin
            used[s] = 0;
            freed++;
          end
        end
        r.evicted_count = (freed > 63) ? 6'd63 : freed[COUNT_W-1:0];
      end
      expected_q.push_back(r);
    endfunction

    // compare one result word with the oldest prediction
    function void check_result(iea_out_t got);
      iea_out_t exp_w;
      if (expected_q.size() == 0) begin
        $error("result word with nothing predicted: %h", got);
        errors++;
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.status !== exp_w.status) begin
        $error("status: expected %0d actual %0d", exp_w.status, got.status);
        errors++;
      end
      if (got.evicted_count !== exp_w.evicted_count) begin
        $error("evicted_count: expected %0d actual %0d",
               exp_w.evicted_count, got.evicted_count);
        errors++;
      end
      if (got.record_dropped !== exp_w.record_dropped) begin
        $error("record_dropped: expected %0d actual %0d",
               exp_w.record_dropped, got.record_dropped);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  iea_in_t             in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  iea_out_t            out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [WINDOW_W-1:0] cfg_data_i;

  aging_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          pressure_armed;
  bit          pressure_done;
  int unsigned pressure_cnt;
  int unsigned cycle_cnt;
  logic [KEY_W-1:0]    key_pool [POOL_N];
  logic [TSTAMP_W-1:0] cur_time;

  idle_entry_aging_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // clock
  always #4 clk_i = ~clk_i;

  // receiver: check results, random stalls, one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    if (pressure_armed && !pressure_done) begin
      out_stall_i <= 1'b1;
      pressure_cnt++;
      if (pressure_cnt >= HOLD_CYCLES) pressure_done = 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // offer one word, with a random gap ahead of it
  task automatic send_word(logic fn, logic [KEY_W-1:0] k, logic [TSTAMP_W-1:0] t);
    iea_in_t w;
    w.func = fn;
    w.process_id = k;
    w.now_time = t;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(w);
  endtask

  // wait until every result is back, then write the window
  task automatic write_window(logic [WINDOW_W-1:0] v);
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.window = v;
  endtask

  // one random word: mostly pooled keys and slowly advancing time
  task automatic send_random(logic [WINDOW_W-1:0] win);
    logic [KEY_W-1:0] k;
    logic [TSTAMP_W-1:0] t;
    logic [TSTAMP_W-1:0] span;
    logic fn;
    span = {24'd0, win} / 4 + 2;
    cur_time = cur_time + ({$urandom, $urandom} % span);
    if ($urandom_range(99) < 4) cur_time = cur_time + {24'd0, win} * 2;
    t = cur_time;
    if ($urandom_range(99) < 3) t = {$urandom, $urandom};
    k = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_N-1)] : $urandom;
    fn = ($urandom_range(99) < 65) ? FN_INSERT : FN_TOUCH;
    send_word(fn, k, t);
  endtask

  initial begin
    logic [WINDOW_W-1:0] windows [5];
    int ph;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    pressure_armed = 0;
    pressure_done = 0;
    pressure_cnt = 0;
    cycle_cnt = 0;
    send_idle_pct = 16;
    recv_idle_pct = 50;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: fill table with extreme keys at time zero, then full table,
    // absent touch, saturating window, full eviction
    send_word(FN_INSERT, 32'h0, 64'h0);
    send_word(FN_INSERT, 32'hFFFF_FFFF, 64'h0);
    for (int i = 2; i < TBL_N; i++) send_word(FN_INSERT, 32'h1000 + i, 64'h0);
    send_word(FN_INSERT, 32'hDEAD_0001, 64'h0);
    send_word(FN_TOUCH, 32'hDEAD_0002, 64'h0);
    for (int i = 2; i < TBL_N + 1; i++) send_word(FN_TOUCH, 32'h1000 + (i % TBL_N), 64'h0);
    send_word(FN_TOUCH, 32'h0, 64'hFFFF_FFFF_FFFF_FFFE);
    send_word(FN_TOUCH, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(FN_INSERT, 32'hA5A5_5A5A, 64'hFFFF_FFFF_FFFF_FFFF);

    // random phases across window settings and idling modes
    windows[0] = '0;
    windows[1] = 40'd37;
    windows[2] = WINDOW_MAX;
    windows[3] = 40'd5000;
    windows[4] = WINDOW_RESET;
    for (ph = 0; ph < 5; ph++) begin
      write_window(windows[ph]);
      if (ph == 2) begin
        send_idle_pct = 50;
        recv_idle_pct = 16;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 1) pressure_armed = 1;
      foreach (key_pool[i]) key_pool[i] = $urandom;
      cur_time = (ph == 2) ? 64'hFFFF_FF00_0000_0000 : {$urandom, $urandom} >> 8;
      for (int n = 0; n < PHASE_WORDS; n++) send_random(windows[ph]);
    end
    in_valid_i <= 1'b0;

    // drain
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/iea_pkg.sv
rtl/core/iea_ctrl.sv
rtl/core/iea_dp.sv
rtl/core/idle_entry_aging_table.sv
rtl/core/iea_chk.sv
test/idle_entry_aging_table_tb.sv
